// File: rtl/dsib_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsib_pkg;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int DATA_W       = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int COUNT_W      = $clog2(CAPACITY + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_DRAINED  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic               kind;
    logic signed [7:0]  sort_key;
    logic        [31:0] payload;
  } item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [7:0]  out_key;
    logic        [31:0] out_payload;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [7:0]       key;
    logic        [DATA_W-1:0] data;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   insert;
    logic   drain;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/dsib_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dsib_cell import dsib_pkg::*; (
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,
  input  wire entry_t    prev_entry,
  input  wire logic      prev_greater,
  input  wire entry_t    next_entry,
  output entry_t         entry,
  output logic           greater
);

  entry_t entry_next;

  // an empty slot counts as greater than any key, so a new word with no greater key stored lands at the end
  assign greater = !occupied || ($signed(entry.key) > $signed(ctl.new_entry.key));

  always_comb begin
    entry_next = entry;
    if (ctl.drain) begin
      entry_next = next_entry;
    end else if (ctl.insert) begin
      if (prev_greater) begin
        entry_next = prev_entry;
      end else if (greater) begin
        entry_next = ctl.new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: rtl/depth_sorted_insert_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// insert: one word per cycle unless a drain is running, result strobed the cycle after start, busy stays low
// drain of n entries: busy while ST_DRAIN shifts the n entries out of cell 0, results registered, one per cycle
// drain of an empty buffer: one result the cycle after start
// the rate is set by the cell chain, which inserts or shifts once per cycle
// rst (synchronous) empties the buffer and idles control; stored entries are not cleared
// results cannot be stalled by the receiver
module depth_sorted_insert_buffer_core import dsib_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item,
  output logic         done,
  output result_t      result
);

  // control registers
  state_t              state, state_next;
  logic [COUNT_W-1:0]  count, count_next;
  logic                done_next;
  result_t             result_next;

  // chain wiring
  cell_ctl_t           ctl;
  entry_t              entries [CAPACITY];
  logic [CAPACITY-1:0] greater;
  logic [CAPACITY-1:0] occupied;

  logic accept;
  logic full;

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (count >= COUNT_W'(CAPACITY));

  // broadcast control: insert into the ordered place, or shift everything toward cell 0
  always_comb begin
    ctl.insert         = accept && (item.kind == KIND_INSERT) && !full;
    ctl.drain          = (state == ST_DRAIN);
    ctl.new_entry.key  = item.sort_key;
    ctl.new_entry.data = item.payload[DATA_W-1:0];
  end

  // row of cells, each holding one slot of the sorted buffer
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_g;

    assign occupied[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign prev_g = greater[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end

    dsib_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (occupied[i]),
      .prev_entry   (prev_e),
      .prev_greater (prev_g),
      .next_entry   (next_e),
      .entry        (entries[i]),
      .greater      (greater[i])
    );
  end

  // sequencer: insert results go out directly, a drain walks the count down
  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    result_next = result;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next               = 1'b1;
          result_next.out_key     = '0;
          result_next.out_payload = '0;
          result_next.last        = 1'b1;
          if (item.kind == KIND_INSERT) begin
            if (full) begin
              result_next.status = STATUS_FULL;
            end else begin
              result_next.status = STATUS_INSERTED;
              count_next         = count + COUNT_W'(1);
            end
          end else if (count == '0) begin
            result_next.status = STATUS_EMPTY;
          end else begin
            // results come from cell 0 while the chain shifts down
            done_next  = 1'b0;
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        done_next               = 1'b1;
        result_next.status      = STATUS_DRAINED;
        result_next.out_key     = entries[0].key;
        result_next.out_payload = 32'(entries[0].data);
        result_next.last        = (count == COUNT_W'(1));
        count_next              = count - COUNT_W'(1);
        if (count == COUNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // result word needs no reset, done marks it
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire
